// ----- rtl/core/dsbh_pkg.sv -----
`default_nettype none
package dsbh_pkg;

    // splitmix64 finalizer multipliers and the length salt
    localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;
    localparam logic [63:0] LEN_MUL   = 64'ha0761d6478bd642f;

    localparam logic [63:0] SEED_FIRST_RESET  = 64'h243f6a8885a308d3;
    localparam logic [63:0] SEED_SECOND_RESET = 64'h13198a2e03707344;

    // input command codes
    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    // configuration register indexes
    typedef enum logic {
        REG_SEED_FIRST  = 1'b0,
        REG_SEED_SECOND = 1'b1
    } t_reg_idx;

    typedef enum logic {
        OP_INIT   = 1'b0,
        OP_ABSORB = 1'b1
    } t_op_kind;

    // one unit of work for the back end
    typedef struct packed {
        t_op_kind    kind;
        logic        rep;    // absorb the word twice
        logic        last;   // emit both lanes when done
        logic [63:0] word;   // word to absorb, or length for init
    } t_op;

    typedef struct packed {
        logic        start;
        logic        init;
        logic [63:0] word;
    } t_mix_cmd;

endpackage
`default_nettype wire

// ----- rtl/core/dsbh_queue.sv -----
`default_nettype none
module dsbh_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd,
    output logic      [WIDTH-1:0] o_rd_data,
    output logic                  o_full,
    output logic                  o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (i_rd && !i_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/dsbh_front.sv -----
`default_nettype none
module dsbh_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic        i_cmd,
    input  wire logic [31:0] i_msg_length,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_op_valid,
    output dsbh_pkg::t_op    o_op
);
    import dsbh_pkg::*;

    logic        r_open, n_open;
    logic [31:0] r_left, n_left;
    logic [63:0] r_wbuf, n_wbuf;
    logic [63:0] r_win, n_win;
    logic [3:0]  r_pos, n_pos;

    logic [63:0] wbuf_add;
    logic [63:0] win_add;
    logic [3:0]  pos_add;
    logic        word_done;
    logic        msg_end;

    always_comb begin
        wbuf_add  = r_wbuf | ({56'd0, i_data_byte} << {r_pos[2:0], 3'b000});
        win_add   = {i_data_byte, r_win[63:8]};
        pos_add   = r_pos + 4'd1;
        word_done = (pos_add[2:0] == 3'd0);
        msg_end   = (r_left == 32'd1);

        n_open     = r_open;
        n_left     = r_left;
        n_wbuf     = r_wbuf;
        n_win      = r_win;
        n_pos      = r_pos;
        o_op_valid = 1'b0;
        o_op       = '{kind: OP_ABSORB, rep: 1'b0, last: 1'b0, word: wbuf_add};

        if (i_accept && i_cmd == CMD_BEGIN) begin
            o_op_valid = 1'b1;
            o_op.kind  = OP_INIT;
            o_op.last  = (i_msg_length == 32'd0);
            o_op.word  = {32'd0, i_msg_length};
            n_open     = (i_msg_length != 32'd0);
            n_left     = i_msg_length;
            n_wbuf     = '0;
            n_win      = '0;
            n_pos      = '0;
        end else if (i_accept && r_open) begin
            n_left = r_left - 32'd1;
            n_win  = win_add;
            n_pos  = pos_add;
            n_wbuf = word_done ? '0 : wbuf_add;
            if (msg_end) begin
                // tail: at exactly 8 mod 16 the window equals the word just closed
                o_op_valid = 1'b1;
                o_op.last  = 1'b1;
                o_op.rep   = (pos_add == 4'd8);
                if (pos_add[3] && pos_add != 4'd8) begin
                    o_op.word = win_add;
                end
                n_open = 1'b0;
                n_wbuf = '0;
                n_win  = '0;
                n_pos  = '0;
            end else if (word_done) begin
                o_op_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_left <= '0;
            r_wbuf <= '0;
            r_win  <= '0;
            r_pos  <= '0;
        end else begin
            r_open <= n_open;
            r_left <= n_left;
            r_wbuf <= n_wbuf;
            r_win  <= n_win;
            r_pos  <= n_pos;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/dsbh_mix.sv -----
`default_nettype none
module dsbh_mix (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire dsbh_pkg::t_mix_cmd i_cmd,
    input  wire logic [63:0]        i_seed,
    output logic                    o_done,
    output logic                    o_busy,
    output logic [63:0]             o_lane
);
    import dsbh_pkg::*;

    typedef enum logic [11:0] {
        M_IDLE  = 12'b000000000001,
        M_SALT0 = 12'b000000000010,
        M_SALT1 = 12'b000000000100,
        M_XSEED = 12'b000000001000,
        M_A0    = 12'b000000010000,
        M_A1    = 12'b000000100000,
        M_A2    = 12'b000001000000,
        M_MID   = 12'b000010000000,
        M_B0    = 12'b000100000000,
        M_B1    = 12'b001000000000,
        M_B2    = 12'b010000000000,
        M_FIN   = 12'b100000000000
    } t_mix_state;

    t_mix_state  r_state, n_state;
    logic [63:0] r_v, n_v;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_lane, n_lane;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [63:0] pre;
    logic [63:0] acc_hi_add;

    assign prod       = 64'(mul_a) * 64'(mul_b);
    assign acc_hi_add = {r_acc[63:32] + prod[31:0], r_acc[31:0]};
    assign o_done     = (r_state == M_FIN);
    assign o_busy     = (r_state != M_IDLE);
    assign o_lane     = r_lane;

    always_comb begin
        n_state = r_state;
        n_v     = r_v;
        n_acc   = r_acc;
        n_lane  = r_lane;
        mul_a   = r_v[31:0];
        mul_b   = MIX_MUL_A[31:0];
        pre     = r_lane ^ i_cmd.word;
        unique case (r_state)
            M_IDLE: begin
                if (i_cmd.start && i_cmd.init) begin
                    n_v     = {32'd0, i_cmd.word[31:0]};
                    n_state = M_SALT0;
                end else if (i_cmd.start) begin
                    n_v     = pre ^ (pre >> 30);
                    n_state = M_A0;
                end
            end
            M_SALT0: begin
                mul_b   = LEN_MUL[31:0];
                n_acc   = prod;
                n_state = M_SALT1;
            end
            M_SALT1: begin
                mul_b   = LEN_MUL[63:32];
                n_acc   = acc_hi_add;
                n_state = M_XSEED;
            end
            M_XSEED: begin
                pre     = i_seed ^ r_acc;
                n_v     = pre ^ (pre >> 30);
                n_state = M_A0;
            end
            M_A0: begin
                n_acc   = prod;
                n_state = M_A1;
            end
            M_A1: begin
                mul_b   = MIX_MUL_A[63:32];
                n_acc   = acc_hi_add;
                n_state = M_A2;
            end
            M_A2: begin
                mul_a   = r_v[63:32];
                n_acc   = acc_hi_add;
                n_state = M_MID;
            end
            M_MID: begin
                n_v     = r_acc ^ (r_acc >> 27);
                n_state = M_B0;
            end
            M_B0: begin
                mul_b   = MIX_MUL_B[31:0];
                n_acc   = prod;
                n_state = M_B1;
            end
            M_B1: begin
                mul_b   = MIX_MUL_B[63:32];
                n_acc   = acc_hi_add;
                n_state = M_B2;
            end
            M_B2: begin
                mul_a   = r_v[63:32];
                mul_b   = MIX_MUL_B[31:0];
                n_acc   = acc_hi_add;
                n_state = M_FIN;
            end
            M_FIN: begin
                n_lane  = r_acc ^ (r_acc >> 31);
                n_state = M_IDLE;
            end
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_lane  <= '0;
        end else begin
            r_state <= n_state;
            r_lane  <= n_lane;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v   <= n_v;
        r_acc <= n_acc;
    end

endmodule
`default_nettype wire

// ----- rtl/core/dsbh_back.sv -----
`default_nettype none
module dsbh_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_empty,
    input  wire dsbh_pkg::t_op i_q_op,
    output logic               o_q_pop,
    output dsbh_pkg::t_mix_cmd o_mix_cmd,
    input  wire logic          i_done_first,
    input  wire logic          i_done_second,
    input  wire logic [63:0]   i_lane_first,
    input  wire logic [63:0]   i_lane_second,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic [63:0]        o_hash_first,
    output logic [63:0]        o_hash_second
);
    import dsbh_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_START = 4'b0010,
        B_WAIT  = 4'b0100,
        B_EMIT  = 4'b1000
    } t_back_state;

    t_back_state r_state, n_state;
    t_op         r_op, n_op;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_hash_first, r_hash_second;
    logic        load;

    assign o_empty       = !r_out_valid;
    assign o_hash_first  = r_hash_first;
    assign o_hash_second = r_hash_second;

    always_comb begin
        n_state         = r_state;
        n_op            = r_op;
        o_q_pop         = 1'b0;
        load            = 1'b0;
        o_mix_cmd.start = (r_state == B_START);
        o_mix_cmd.init  = (r_op.kind == OP_INIT);
        o_mix_cmd.word  = r_op.word;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_op    = i_q_op;
                    n_state = B_START;
                end
            end
            B_START: n_state = B_WAIT;
            B_WAIT: begin
                if (i_done_first && i_done_second) begin
                    if (r_op.rep) begin
                        n_op.rep = 1'b0;
                        n_state  = B_START;
                    end else if (r_op.last) begin
                        n_state = B_EMIT;
                    end else begin
                        n_state = B_IDLE;
                    end
                end
            end
            B_EMIT: begin
                if (!r_out_valid || i_pop) begin
                    load    = 1'b1;
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase

        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        if (load) begin
            r_hash_first  <= i_lane_first | 64'd1;
            r_hash_second <= i_lane_second | 64'd1;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/dual_seed_byte_hash_top.sv -----
`default_nettype none
// Result timing: with the back end idle and the result slot free, a result follows the
//   request that ends its message by one mix, by two mixes when the last eight bytes are
//   mixed twice, and by the length salt plus one mix for an empty message; queued ops add more.
// Throughput: one request per cycle while the op queue has room; the back end runs one op at
//   a time, a word op per eight bytes and an init op per begin that also runs the length salt.
// Reset: synchronous, active low; clears all control state, seeds return to defaults.
module dual_seed_byte_hash_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input request channel
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic        i_cmd,
    input  wire logic [31:0] i_msg_length,
    input  wire logic [7:0]  i_data_byte,
    // result channel
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [63:0]      o_hash_first,
    output logic [63:0]      o_hash_second,
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);
    import dsbh_pkg::*;

    logic [63:0] r_seed_first;
    logic [63:0] r_seed_second;

    logic     accept;
    logic     op_valid;
    t_op      op_in;
    t_op      op_out;
    logic     q_empty;
    logic     q_pop;
    t_mix_cmd mix_cmd;
    logic     done_first, done_second;
    logic     busy_first, busy_second;
    logic [63:0] lane_first, lane_second;

    // Seeds are only sampled by an init op, so writes while idle need no staging.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_first  <= SEED_FIRST_RESET;
            r_seed_second <= SEED_SECOND_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_SEED_FIRST:  r_seed_first  <= i_cfg_data;
                REG_SEED_SECOND: r_seed_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front end: takes every request the queue has room for, byte or begin,
    // and turns them into init / absorb ops.
    assign accept = i_push && !o_full;

    dsbh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_cmd        (i_cmd),
        .i_msg_length (i_msg_length),
        .i_data_byte  (i_data_byte),
        .o_op_valid   (op_valid),
        .o_op         (op_in)
    );

    dsbh_queue #(
        .WIDTH ($bits(t_op)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (op_valid),
        .i_wr_data (op_in),
        .i_rd      (q_pop),
        .o_rd_data (op_out),
        .o_full    (o_full),
        .o_empty   (q_empty)
    );

    // Back end: runs one op at a time on both lane units, holds the result.
    dsbh_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_op        (op_out),
        .o_q_pop       (q_pop),
        .o_mix_cmd     (mix_cmd),
        .i_done_first  (done_first),
        .i_done_second (done_second),
        .i_lane_first  (lane_first),
        .i_lane_second (lane_second),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_hash_first  (o_hash_first),
        .o_hash_second (o_hash_second)
    );

    // Lane units: one 32x32 multiplier each, three passes per 64-bit mix product, two for the length salt.
    dsbh_mix u_mix_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mix_cmd),
        .i_seed  (r_seed_first),
        .o_done  (done_first),
        .o_busy  (busy_first),
        .o_lane  (lane_first)
    );

    dsbh_mix u_mix_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mix_cmd),
        .i_seed  (r_seed_second),
        .o_done  (done_second),
        .o_busy  (busy_second),
        .o_lane  (lane_second)
    );

    // both lanes run the same schedule
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_first == done_second)
        else $error("lane units out of step");

    // a new mix only starts on idle lane units
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mix_cmd.start |-> (!busy_first && !busy_second))
        else $error("mix started while busy");

    // reset drops any held result
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result held across reset");

endmodule
`default_nettype wire
